// ===== design/mtep_pkg.sv =====
// Types and constants shared by the MIDI track event parser.
`default_nettype none

package mtep_pkg;

  // Parser phase within one track event
  typedef enum logic [2:0] {
    PH_DELTA   = 3'd0,
    PH_STATUS  = 3'd1,
    PH_MTYPE   = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DATA1   = 3'd5,
    PH_DATA2   = 3'd6,
    PH_SKIP    = 3'd7
  } phase_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_CHAN    = 3'd0,
    KIND_SYSEX   = 3'd1,
    KIND_META    = 3'd2,
    KIND_PAYLOAD = 3'd3,
    KIND_END     = 3'd4
  } kind_t;

  // Status byte codes
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] ST_NONE      = 8'h00;

  // Channel message codes that carry one data byte
  localparam logic [3:0] CODE_PROGRAM  = 4'hC;
  localparam logic [3:0] CODE_PRESSURE = 4'hD;

  // One result beat without its last flag
  typedef struct packed {
    kind_t       kind;
    logic [31:0] tick_time;
    logic [3:0]  msg_code;
    logic [3:0]  chan;
    logic [7:0]  param_one;
    logic [7:0]  param_two;
    logic [7:0]  status_or_type;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
  } result_t;

  // What one accepted byte hands to the result stage
  typedef struct packed {
    logic        main_v;
    result_t     main;
    logic        end_v;
    logic [31:0] end_time;
  } push_t;

  function automatic logic one_data_byte(input logic [7:0] status);
    return (status[7:4] == CODE_PROGRAM) || (status[7:4] == CODE_PRESSURE);
  endfunction

endpackage

`default_nettype wire

// ===== design/mtep_if.sv =====
// Channel interfaces for track bytes in and parsed results out.
`default_nettype none

interface mtep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] track_byte;
  logic       end_of_track;

  modport source (output valid, output track_byte, output end_of_track, input ready);
  modport sink (input valid, input track_byte, input end_of_track, output ready);
endinterface

interface mtep_out_if;
  logic            valid;
  logic            ready;
  mtep_pkg::kind_t kind;
  logic [31:0]     tick_time;
  logic [3:0]      msg_code;
  logic [3:0]      chan;
  logic [7:0]      param_one;
  logic [7:0]      param_two;
  logic [7:0]      status_or_type;
  logic [31:0]     payload_length;
  logic [7:0]      payload_byte;
  logic            last_of_run;

  modport source (
    output valid, output kind, output tick_time, output msg_code, output chan,
    output param_one, output param_two, output status_or_type,
    output payload_length, output payload_byte, output last_of_run,
    input ready
  );
  modport sink (
    input valid, input kind, input tick_time, input msg_code, input chan,
    input param_one, input param_two, input status_or_type,
    input payload_length, input payload_byte, input last_of_run,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/mtep_result_stage.sv =====
// Two-entry result holding stage: one event result plus an optional end result.
`default_nettype none

module mtep_result_stage (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push_en,
  input  mtep_pkg::push_t      push,
  output logic                 push_ready,
  mtep_out_if.source           out_if
);
  import mtep_pkg::*;

  logic        main_v_r, main_v_nxt;
  result_t     main_r;
  logic        end_v_r, end_v_nxt;
  logic [31:0] end_time_r;
  logic        pop;

  assign pop = out_if.valid && out_if.ready;

  // Room for a new byte once everything held is gone after this cycle
  assign push_ready = (!main_v_r && !end_v_r) || (pop && !(main_v_r && end_v_r));

  // Valid bits: pop the event result first, then the end result
  always_comb begin
    main_v_nxt = main_v_r;
    end_v_nxt  = end_v_r;
    if (pop) begin
      if (main_v_r) begin
        main_v_nxt = 1'b0;
      end else begin
        end_v_nxt = 1'b0;
      end
    end
    if (push_en) begin
      main_v_nxt = push.main_v;
      end_v_nxt  = push.end_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      end_v_r  <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      end_v_r  <= end_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (push_en) begin
      main_r     <= push.main;
      end_time_r <= push.end_time;
    end
  end

  // Output mux
  always_comb begin
    out_if.valid          = main_v_r || end_v_r;
    out_if.kind           = main_r.kind;
    out_if.tick_time      = main_r.tick_time;
    out_if.msg_code       = main_r.msg_code;
    out_if.chan           = main_r.chan;
    out_if.param_one      = main_r.param_one;
    out_if.param_two      = main_r.param_two;
    out_if.status_or_type = main_r.status_or_type;
    out_if.payload_length = main_r.payload_length;
    out_if.payload_byte   = main_r.payload_byte;
    out_if.last_of_run    = !end_v_r;
    if (!main_v_r) begin
      out_if.kind           = KIND_END;
      out_if.tick_time      = end_time_r;
      out_if.msg_code       = '0;
      out_if.chan           = '0;
      out_if.param_one      = '0;
      out_if.param_two      = '0;
      out_if.status_or_type = '0;
      out_if.payload_length = '0;
      out_if.payload_byte   = '0;
      out_if.last_of_run    = 1'b1;
    end
  end

  // A pushed result shows up on the next cycle
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push_en && (push.main_v || push.end_v) |=> out_if.valid)
    else $error("pushed result not presented");

  // A stalled event result is kept
  a_main_held: assert property (@(posedge clk) disable iff (!rst_n)
    main_v_r && !pop |=> main_v_r)
    else $error("stalled result dropped");

  // Event result leaves before the end result
  a_end_order: assert property (@(posedge clk) disable iff (!rst_n)
    pop && main_v_r && end_v_r && !push_en |=> !main_v_r && end_v_r)
    else $error("end result out of order");

endmodule

`default_nettype wire

// ===== design/midi_track_event_parser.sv =====
// Top level of the MIDI track chunk event parser.
//
//  channel  dir  payload                                   handshake
//  in_if    in   track_byte, end_of_track                  valid/ready
//  out_if   out  kind, tick_time, msg_code, chan, params,  valid/ready
//                status_or_type, payload_length,
//                payload_byte, last_of_run
//
// One byte is accepted per cycle while the result stage has room; its results
// are registered and presented on the next cycle. A byte yields at most two
// results (event plus end); when two are pending the input waits while they drain.
// rst_n is synchronous, active low, and returns the parser to the delta phase.
// Output stalls hold the result stage; input ready follows it combinationally.
`default_nettype none

module midi_track_event_parser #(
  parameter int TIME_BITS = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  mtep_in_if.sink     in_if,
  mtep_out_if.source  out_if
);
  import mtep_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [7:0]             run_status_r, run_status_nxt;
  logic [31:0]            vlq_r, vlq_nxt;
  logic [TIME_BITS-1:0]   ticks_r, ticks_nxt, ticks_upd;
  logic [31:0]            remain_r, remain_nxt;
  logic [7:0]             held_status_r, held_status_nxt;
  logic [7:0]             held_data_r, held_data_nxt;
  logic                   is_meta_r, is_meta_nxt;

  logic                   in_fire;
  logic                   stage_ready;
  push_t                  push;
  logic [7:0]             b;
  logic [31:0]            acc_shift;
  logic [31:0]            remain_dec;
  logic [TIME_BITS-1:0]   acc_ext;
  logic [TIME_BITS-1:0]   tick_sum;
  logic [31:0]            ticks_cur32;
  logic [31:0]            ticks_upd32;

  assign b          = in_if.track_byte;
  assign in_if.ready = stage_ready;
  assign in_fire    = in_if.valid && stage_ready;

  // VLQ step: shift in seven bits
  assign acc_shift  = {vlq_r[24:0], b[6:0]};
  assign remain_dec = remain_r - 32'd1;
  assign tick_sum   = ticks_r + acc_ext;

  // Width adaptation between the tick counter and 32-bit values
  generate
    if (TIME_BITS > 32) begin : g_wide
      assign acc_ext     = {{(TIME_BITS-32){1'b0}}, acc_shift};
      assign ticks_cur32 = ticks_r[31:0];
      assign ticks_upd32 = ticks_upd[31:0];
    end else if (TIME_BITS == 32) begin : g_equal
      assign acc_ext     = acc_shift;
      assign ticks_cur32 = ticks_r;
      assign ticks_upd32 = ticks_upd;
    end else begin : g_narrow
      assign acc_ext     = acc_shift[TIME_BITS-1:0];
      assign ticks_cur32 = {{(32-TIME_BITS){1'b0}}, ticks_r};
      assign ticks_upd32 = {{(32-TIME_BITS){1'b0}}, ticks_upd};
    end
  endgenerate

  // Next state and results for one byte
  always_comb begin
    phase_nxt       = phase_r;
    run_status_nxt  = run_status_r;
    vlq_nxt         = vlq_r;
    ticks_upd       = ticks_r;
    remain_nxt      = remain_r;
    held_status_nxt = held_status_r;
    held_data_nxt   = held_data_r;
    is_meta_nxt     = is_meta_r;

    push                = '0;
    push.main.kind      = KIND_CHAN;
    push.main.tick_time = ticks_cur32;

    unique case (phase_r)
      PH_DELTA: begin
        vlq_nxt = acc_shift;
        if (!b[7]) begin
          ticks_upd = tick_sum;
          vlq_nxt   = '0;
          phase_nxt = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
          held_status_nxt = b;
          is_meta_nxt     = 1'b0;
          vlq_nxt         = '0;
          phase_nxt       = PH_LEN;
        end else if (b == ST_META) begin
          phase_nxt = PH_MTYPE;
        end else if (b >= ST_SYSEX) begin
          // other system status: swallow one byte
          run_status_nxt = ST_NONE;
          phase_nxt      = PH_SKIP;
        end else if (b[7]) begin
          run_status_nxt  = b;
          held_status_nxt = b;
          phase_nxt       = PH_DATA1;
        end else if (run_status_r == ST_NONE) begin
          phase_nxt = PH_DELTA;
        end else if (one_data_byte(run_status_r)) begin
          push.main_v         = 1'b1;
          push.main.msg_code  = run_status_r[7:4];
          push.main.chan      = run_status_r[3:0];
          push.main.param_one = b;
          phase_nxt           = PH_DELTA;
        end else begin
          held_status_nxt = run_status_r;
          held_data_nxt   = b;
          phase_nxt       = PH_DATA2;
        end
      end
      PH_MTYPE: begin
        held_status_nxt = b;
        is_meta_nxt     = 1'b1;
        vlq_nxt         = '0;
        phase_nxt       = PH_LEN;
      end
      PH_LEN: begin
        vlq_nxt = acc_shift;
        if (!b[7]) begin
          push.main_v              = 1'b1;
          push.main.kind           = is_meta_r ? KIND_META : KIND_SYSEX;
          push.main.status_or_type = held_status_r;
          push.main.payload_length = acc_shift;
          remain_nxt               = acc_shift;
          vlq_nxt                  = '0;
          phase_nxt                = (acc_shift == 32'd0) ? PH_DELTA : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        push.main_v            = 1'b1;
        push.main.kind         = KIND_PAYLOAD;
        push.main.payload_byte = b;
        remain_nxt             = remain_dec;
        if (remain_dec == 32'd0) begin
          phase_nxt = PH_DELTA;
        end
      end
      PH_DATA1: begin
        if (one_data_byte(held_status_r)) begin
          push.main_v         = 1'b1;
          push.main.msg_code  = held_status_r[7:4];
          push.main.chan      = held_status_r[3:0];
          push.main.param_one = b;
          phase_nxt           = PH_DELTA;
        end else begin
          held_data_nxt = b;
          phase_nxt     = PH_DATA2;
        end
      end
      PH_DATA2: begin
        push.main_v         = 1'b1;
        push.main.msg_code  = held_status_r[7:4];
        push.main.chan      = held_status_r[3:0];
        push.main.param_one = held_data_r;
        push.main.param_two = b;
        phase_nxt           = PH_DELTA;
      end
      PH_SKIP: begin
        phase_nxt = PH_DELTA;
      end
    endcase

    ticks_nxt     = ticks_upd;
    push.end_time = ticks_upd32;

    // End mark: emit the total time and start a fresh chunk
    if (in_if.end_of_track) begin
      push.end_v      = 1'b1;
      phase_nxt       = PH_DELTA;
      run_status_nxt  = ST_NONE;
      vlq_nxt         = '0;
      ticks_nxt       = '0;
      remain_nxt      = '0;
      held_status_nxt = ST_NONE;
      held_data_nxt   = '0;
      is_meta_nxt     = 1'b0;
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_DELTA;
      run_status_r  <= ST_NONE;
      vlq_r         <= '0;
      ticks_r       <= '0;
      remain_r      <= '0;
      held_status_r <= ST_NONE;
      held_data_r   <= '0;
      is_meta_r     <= 1'b0;
    end else if (in_fire) begin
      phase_r       <= phase_nxt;
      run_status_r  <= run_status_nxt;
      vlq_r         <= vlq_nxt;
      ticks_r       <= ticks_nxt;
      remain_r      <= remain_nxt;
      held_status_r <= held_status_nxt;
      held_data_r   <= held_data_nxt;
      is_meta_r     <= is_meta_nxt;
    end
  end

  mtep_result_stage u_result_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_en    (in_fire),
    .push       (push),
    .push_ready (stage_ready),
    .out_if     (out_if)
  );

  // End of chunk returns the parser to its reset state
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_if.end_of_track
      |=> phase_r == PH_DELTA && run_status_r == ST_NONE && ticks_r == '0)
    else $error("state not cleared after end of chunk");

  // Payload phase always has bytes left to count
  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> remain_r != 32'd0)
    else $error("payload phase with nothing remaining");

  // Accumulator is clear whenever a status byte is expected
  a_vlq_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_STATUS |-> vlq_r == 32'd0)
    else $error("stale VLQ accumulator");

endmodule

`default_nettype wire
